FILE: hw/rtl/hfm_pkg.sv
// shared types and constants for the heartbeat frame monitor
package hfm_pkg;

  localparam int FRAME_LEN    = 17;
  localparam int POS_W        = 5;
  localparam int SLOT_N       = 16;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_FIELDS_W = 37;
  localparam int OUT_TDATA_W  = 40;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HEADER  = 3'd1,
    ST_COMMAND = 3'd2,
    ST_HDR_SUM = 3'd3,
    ST_TOT_SUM = 3'd4
  } frame_status_t;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_t;

  typedef enum logic {
    REP_FRAME = 1'b0,
    REP_TICK  = 1'b1
  } report_kind_t;

  typedef enum logic {
    REG_ENABLE_MASK = 1'b0,
    REG_UNUSED      = 1'b1
  } reg_index_t;

  typedef struct packed {
    frame_status_t       status;
    logic [SLOT_N-1:0]   slots;
  } frame_res_t;

  typedef struct packed {
    logic [SLOT_N-1:0] alive_now;
    logic [SLOT_N-1:0] lost;
    logic              alarm;
    logic              skipped;
  } tick_res_t;

endpackage

FILE: hw/rtl/hfm_frame_chk.sv
// frame byte checker: header, command and checksum checks with zero padding
module hfm_frame_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output hfm_pkg::frame_res_t res
);
  import hfm_pkg::*;

  localparam logic [POS_W-1:0] POS_HDR0  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HDR2  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CMD0  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_CMD1  = POS_W'(8);
  localparam logic [POS_W-1:0] POS_HSUM  = POS_W'(11);
  localparam logic [POS_W-1:0] POS_HIGH  = POS_W'(12);
  localparam logic [POS_W-1:0] POS_LOW   = POS_W'(13);
  localparam logic [POS_W-1:0] POS_TSUM  = POS_W'(16);
  localparam logic [POS_W-1:0] POS_END   = POS_W'(FRAME_LEN);
  localparam logic [7:0]       SYNC_BYTE = 8'hEF;
  localparam logic [7:0]       CMD_BYTE0 = 8'hFF;
  localparam logic [7:0]       CMD_BYTE1 = 8'h16;

  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       sum, sum_next;
  frame_status_t    err, err_next;
  logic [7:0]       low_bits, low_bits_next;
  logic [7:0]       high_bits, high_bits_next;
  frame_status_t    byte_err;
  frame_status_t    pad_err;
  frame_status_t    final_err;

  always_comb begin
    byte_err = ST_OK;
    case (pos)
      POS_HDR0, POS_HDR1: if (data_byte != SYNC_BYTE) byte_err = ST_HEADER;
      POS_HDR2:           if (data_byte != 8'h00) byte_err = ST_HEADER;
      POS_CMD0:           if (data_byte != CMD_BYTE0) byte_err = ST_COMMAND;
      POS_CMD1:           if (data_byte != CMD_BYTE1) byte_err = ST_COMMAND;
      POS_HSUM:           if (data_byte != sum) byte_err = ST_HDR_SUM;
      POS_TSUM:           if (data_byte != sum) byte_err = ST_TOT_SUM;
      default:            byte_err = ST_OK;
    endcase
  end

  always_comb begin
    pos_next       = pos;
    sum_next       = sum;
    err_next       = err;
    low_bits_next  = low_bits;
    high_bits_next = high_bits;
    if (pos < POS_END) begin
      pos_next = pos + POS_W'(1);
      if (err == ST_OK) err_next = byte_err;
      if (pos < POS_TSUM) sum_next = sum + data_byte;
      if (pos == POS_HIGH) high_bits_next = data_byte;
      if (pos == POS_LOW) low_bits_next = data_byte;
    end
  end

  // missing bytes read as zero; the sum no longer moves while padding
  always_comb begin
    if (pos_next <= POS_HDR1) begin
      pad_err = ST_HEADER;
    end else if (pos_next <= POS_CMD1) begin
      pad_err = ST_COMMAND;
    end else if (pos_next <= POS_TSUM && sum_next != 8'h00) begin
      pad_err = (pos_next <= POS_HSUM) ? ST_HDR_SUM : ST_TOT_SUM;
    end else begin
      pad_err = ST_OK;
    end
    final_err  = (err_next != ST_OK) ? err_next : pad_err;
    res.status = final_err;
    res.slots  = (final_err == ST_OK) ? {high_bits_next, low_bits_next} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      sum       <= '0;
      err       <= ST_OK;
      low_bits  <= '0;
      high_bits <= '0;
    end else if (step) begin
      if (last_byte) begin
        pos       <= '0;
        sum       <= '0;
        err       <= ST_OK;
        low_bits  <= '0;
        high_bits <= '0;
      end else begin
        pos       <= pos_next;
        sum       <= sum_next;
        err       <= err_next;
        low_bits  <= low_bits_next;
        high_bits <= high_bits_next;
      end
    end
  end

endmodule

FILE: hw/rtl/hfm_slot_track.sv
// per-slot alive tracking and tick evaluation
module hfm_slot_track (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        frame_end,
  input  logic [hfm_pkg::SLOT_N-1:0]  slot_bits,
  input  logic                        tick,
  input  logic [hfm_pkg::SLOT_N-1:0]  enable_mask,
  output hfm_pkg::tick_res_t          res
);
  import hfm_pkg::*;

  logic [SLOT_N-1:0] seen_alive;
  logic [SLOT_N-1:0] last_ok;
  logic              skip_next_tick;
  logic              first_tick;
  logic [SLOT_N-1:0] now_mask;
  logic [SLOT_N-1:0] lost_mask;
  logic              changed;

  always_comb begin
    now_mask    = enable_mask & seen_alive & ~last_ok;
    lost_mask   = enable_mask & last_ok & ~seen_alive;
    changed     = |(now_mask | lost_mask);
    res.skipped = skip_next_tick;
    res.alive_now = skip_next_tick ? '0 : now_mask;
    res.lost      = skip_next_tick ? '0 : lost_mask;
    res.alarm     = !skip_next_tick && changed && !first_tick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_alive     <= '0;
      last_ok        <= '0;
      skip_next_tick <= 1'b1;
      first_tick     <= 1'b1;
    end else if (tick) begin
      if (skip_next_tick) begin
        skip_next_tick <= 1'b0;
      end else begin
        last_ok        <= (last_ok | now_mask) & ~lost_mask;
        skip_next_tick <= changed;
        seen_alive     <= '0;
        first_tick     <= 1'b0;
      end
    end else if (frame_end) begin
      seen_alive <= seen_alive | slot_bits;
    end
  end

endmodule

FILE: hw/rtl/heartbeat_frame_monitor_unit.sv
// heartbeat frame monitor top level: stream ports, register port, result register
// throughput: one input beat per cycle unless m_tready holds back the result beat;
// each beat goes through the input register, one pass of check logic and
// the result register
// frame bytes without the end mark give no result beat
// reset (rst, synchronous): clears frame state, alive tracking and enable_mask;
// the first tick after reset is reported as skipped
module heartbeat_frame_monitor_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [hfm_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] data_byte
  input  logic                             s_tuser,  // [0] req_type
  input  logic                             s_tlast,  // last_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [2:0] frame_status, [18:3] alive_now_mask, [34:19] lost_mask,
  // [35] raise_alarm, [36] tick_skipped, [39:37] zero
  output logic [hfm_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                             m_tuser,  // [0] report_kind
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hfm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [hfm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [hfm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import hfm_pkg::*;

  logic              in_valid;
  req_type_t         in_type;
  logic [7:0]        in_data;
  logic              in_last;
  logic              advance;
  logic              byte_step;
  logic              tick_step;
  logic              produce;
  logic [SLOT_N-1:0] enable_mask;
  reg_index_t        reg_sel;
  frame_res_t        frame_res;
  tick_res_t         tick_res;
  logic [OUT_FIELDS_W-1:0] out_fields;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[APB_ADDR_W-1]);
  assign prdata  = (reg_sel == REG_ENABLE_MASK) ?
                   {{(APB_DATA_W-SLOT_N){1'b0}}, enable_mask} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_ENABLE_MASK) begin
      enable_mask <= pwdata[SLOT_N-1:0];
    end
  end

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign byte_step = advance && in_type == REQ_BYTE;
  assign tick_step = advance && in_type == REQ_TICK;
  assign produce   = tick_step || (byte_step && in_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type <= req_type_t'(s_tuser);
      in_data <= s_tdata[7:0];
      in_last <= s_tlast;
    end
  end

  hfm_frame_chk u_frame_chk (
    .clk       (clk),
    .rst       (rst),
    .step      (byte_step),
    .data_byte (in_data),
    .last_byte (in_last),
    .res       (frame_res)
  );

  hfm_slot_track u_slot_track (
    .clk         (clk),
    .rst         (rst),
    .frame_end   (byte_step && in_last),
    .slot_bits   (frame_res.slots),
    .tick        (tick_step),
    .enable_mask (enable_mask),
    .res         (tick_res)
  );

  always_comb begin
    if (in_type == REQ_TICK) begin
      out_fields = {tick_res.skipped, tick_res.alarm, tick_res.lost,
                    tick_res.alive_now, ST_OK};
    end else begin
      out_fields = {1'b0, 1'b0, {SLOT_N{1'b0}}, {SLOT_N{1'b0}}, frame_res.status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (produce) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      m_tdata <= {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_fields};
      m_tuser <= (in_type == REQ_TICK) ? REP_TICK : REP_FRAME;
    end
  end

endmodule

FILE: hw/rtl/hfm_checker.sv
// port-level checks for the heartbeat frame monitor, bound to the top level
module hfm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [hfm_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tuser
);
  import hfm_pkg::*;

  a_frame_beat_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == REP_FRAME |-> m_tdata[OUT_TDATA_W-1:3] == '0)
    else $error("frame beat carries tick fields");

  a_tick_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == REP_TICK |-> m_tdata[2:0] == ST_OK)
    else $error("tick beat carries a frame status");

  a_skipped_tick_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == REP_TICK && m_tdata[36] |-> m_tdata[35:3] == '0)
    else $error("skipped tick reports changes");

  a_alive_lost_disjoint: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[18:3] & m_tdata[34:19]) == '0 && m_tdata[2:0] <= ST_TOT_SUM)
    else $error("slot both returned and lost, or bad status");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

endmodule

bind heartbeat_frame_monitor_unit hfm_checker u_hfm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
